### hdl/sacs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacs_pkg
// Shared types and constants for the sprite alpha class scanner.
// ----------------------------------------------------------------------------
package sacs_pkg;

   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned LANES          = 4;
   localparam int unsigned ALPHA_LANE     = 3;
   localparam int unsigned COUNT_W        = 13;
   localparam int unsigned CHAN_W         = 3;
   localparam int unsigned CSR_DATA_W     = 13;
   localparam int unsigned DEF_MAX_PIXELS = 4096;

   localparam logic [BYTE_W-1:0]  BYTE_MIN  = 8'd0;
   localparam logic [BYTE_W-1:0]  BYTE_MAX  = 8'd255;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

   localparam logic [CHAN_W-1:0]  CHAN_RGB         = 3'd3;
   localparam logic [CHAN_W-1:0]  CHAN_RESET       = 3'd4;
   localparam logic [COUNT_W-1:0] SPRITE_PIX_RESET = 13'd64;

   typedef enum logic [0:0] {
      CSR_CHANNEL_COUNT = 1'b0,
      CSR_SPRITE_PIXELS = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      CLS_INVISIBLE       = 4'd0,
      CLS_OPAQUE_CRGB     = 4'd1,
      CLS_OPAQUE          = 4'd2,
      CLS_ONEBIT_CRGB     = 4'd3,
      CLS_ONEBIT          = 4'd4,
      CLS_SEMI_CRGB_CA    = 4'd5,
      CLS_SEMI_CRGB       = 4'd6,
      CLS_SEMI_CA         = 4'd7,
      CLS_SEMI            = 4'd8
   } class_type;

   // Per-pixel verdict from the merge stage.
   typedef struct packed {
      logic      class_valid;
      class_type class_code;
      logic      size_error;
   } verdict_type;

endpackage : sacs_pkg
`default_nettype wire

### hdl/sacs_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacs_lane
// One channel lane: keeps the first byte of a sprite and a constant flag.
// ----------------------------------------------------------------------------
module sacs_lane
   import sacs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              at_first,
   input  wire logic              last,
   input  wire logic [BYTE_W-1:0] px,
   output logic                   const_upd
);

   logic [BYTE_W-1:0] first_ff, first_in;
   logic              const_ff, const_in;

   // flag as it stands after this pixel
   assign const_upd = at_first ? const_ff : (const_ff && (first_ff == px));

   always_comb begin
      first_in = first_ff;
      const_in = const_ff;
      if (advance) begin
         if (last) begin
            const_in = 1'b1;
         end else begin
            const_in = const_upd;
            if (at_first) begin
               first_in = px;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      if (reset) begin
         const_ff <= 1'b1;
      end else begin
         const_ff <= const_in;
      end
   end

endmodule : sacs_lane
`default_nettype wire

### hdl/sacs_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacs_merge
// Merges lane flags with alpha range flags and pixel count into a verdict.
// ----------------------------------------------------------------------------
module sacs_merge
   import sacs_pkg::*;
#(
   parameter int unsigned MAX_SPRITE_PIXELS = DEF_MAX_PIXELS
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               last,
   input  wire logic [BYTE_W-1:0]  alpha,
   input  wire logic [LANES-1:0]   const_upd,
   input  wire logic [COUNT_W-1:0] sprite_pixels,
   output logic                    at_first,
   output verdict_type             verdict
);

   localparam int unsigned CMP_W = 18;
   localparam logic [CMP_W-1:0] MAX_PIX = CMP_W'(MAX_SPRITE_PIXELS);

   logic               first_ff, first_in;
   logic               zero_ff, zero_in, full_ff, full_in, mid_ff, mid_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               zero_upd, full_upd, mid_upd;
   logic [COUNT_W-1:0] count_upd;
   logic               rgb_flat, alpha_flat, bad;
   class_type          code;

   assign at_first = first_ff;

   assign zero_upd  = zero_ff | (alpha == BYTE_MIN);
   assign full_upd  = full_ff | (alpha == BYTE_MAX);
   assign mid_upd   = mid_ff  | ((alpha != BYTE_MIN) && (alpha != BYTE_MAX));
   assign count_upd = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   assign rgb_flat   = &const_upd[ALPHA_LANE-1:0];
   assign alpha_flat = const_upd[ALPHA_LANE];

   assign bad = (sprite_pixels == '0)
             || ({{(CMP_W-COUNT_W){1'b0}}, sprite_pixels} > MAX_PIX)
             || (count_upd != sprite_pixels);

   always_comb begin
      if (!mid_upd && !full_upd) begin
         code = CLS_INVISIBLE;
      end else if (!mid_upd && !zero_upd) begin
         code = rgb_flat ? CLS_OPAQUE_CRGB : CLS_OPAQUE;
      end else if (!mid_upd) begin
         code = rgb_flat ? CLS_ONEBIT_CRGB : CLS_ONEBIT;
      end else if (rgb_flat) begin
         code = alpha_flat ? CLS_SEMI_CRGB_CA : CLS_SEMI_CRGB;
      end else begin
         code = alpha_flat ? CLS_SEMI_CA : CLS_SEMI;
      end
   end

   always_comb begin
      verdict.class_valid = last && !bad;
      verdict.class_code  = (last && !bad) ? code : CLS_INVISIBLE;
      verdict.size_error  = last && bad;
   end

   always_comb begin
      first_in = first_ff;
      zero_in  = zero_ff;
      full_in  = full_ff;
      mid_in   = mid_ff;
      count_in = count_ff;
      if (advance) begin
         if (last) begin
            first_in = 1'b1;
            zero_in  = 1'b0;
            full_in  = 1'b0;
            mid_in   = 1'b0;
            count_in = '0;
         end else begin
            first_in = 1'b0;
            zero_in  = zero_upd;
            full_in  = full_upd;
            mid_in   = mid_upd;
            count_in = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         zero_ff  <= 1'b0;
         full_ff  <= 1'b0;
         mid_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         first_ff <= first_in;
         zero_ff  <= zero_in;
         full_ff  <= full_in;
         mid_ff   <= mid_in;
         count_ff <= count_in;
      end
   end

endmodule : sacs_merge
`default_nettype wire

### hdl/sprite_alpha_class_scan_top.sv
`timescale 1ns / 1ps
`default_nettype none
// The rsp word for an accepted req word is registered and valid in the next cycle.
// Throughput: one pixel per cycle while rsp_tready is high; the rsp output register frees up in the
//   same cycle it is drained, so req_tready stays high under steady flow.
// Reset: synchronous, active high; config returns to 4 channels / 64 pixels,
//   scan state to start-of-sprite, rsp channel empty.
// ----------------------------------------------------------------------------
// sprite_alpha_class_scan_top
// Pixel stream pass-through with alpha split and per-sprite transparency
// classification: four channel lanes plus a merge stage, one output register.
// ----------------------------------------------------------------------------
module sprite_alpha_class_scan_top
   import sacs_pkg::*;
#(
   parameter int unsigned MAX_SPRITE_PIXELS = DEF_MAX_PIXELS
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // config write port
   input  wire logic                  csr_we,
   input  wire logic [0:0]            csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   // pixel in
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [39:0]           req_tdata,  // red, green, blue, alpha_in, sprite_slot
   input  wire logic                  req_tlast,  // last_pixel
   // pixel out
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [47:0]                rsp_tdata   // rgb_out, alpha_out, slot_out,
                                                  // class_valid, class_code, size_error, pad
);

   // ---- config registers ----
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [COUNT_W-1:0] pix_ff, pix_in;

   always_comb begin
      chan_in = chan_ff;
      pix_in  = pix_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_CHANNEL_COUNT: chan_in = csr_wdata[CHAN_W-1:0];
            CSR_SPRITE_PIXELS: pix_in  = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= CHAN_RESET;
         pix_ff  <= SPRITE_PIX_RESET;
      end else begin
         chan_ff <= chan_in;
         pix_ff  <= pix_in;
      end
   end

   // ---- input unpack ----
   logic                          accept;
   logic [LANES-1:0][BYTE_W-1:0]  px;
   logic [BYTE_W-1:0]             slot;

   assign accept = req_tvalid && req_tready;
   assign px[0]  = req_tdata[7:0];
   assign px[1]  = req_tdata[15:8];
   assign px[2]  = req_tdata[23:16];
   // three-channel mode: alpha plane is fully opaque
   assign px[ALPHA_LANE] = (chan_ff == CHAN_RGB) ? BYTE_MAX : req_tdata[31:24];
   assign slot   = req_tdata[39:32];

   // ---- channel lanes ----
   logic             at_first;
   logic [LANES-1:0] const_upd;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      sacs_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .advance   (accept),
         .at_first  (at_first),
         .last      (req_tlast),
         .px        (px[g]),
         .const_upd (const_upd[g])
      );
   end

   // ---- merge: alpha range flags, count check, class code ----
   verdict_type verdict;

   sacs_merge #(
      .MAX_SPRITE_PIXELS (MAX_SPRITE_PIXELS)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .advance       (accept),
      .last          (req_tlast),
      .alpha         (px[ALPHA_LANE]),
      .const_upd     (const_upd),
      .sprite_pixels (pix_ff),
      .at_first      (at_first),
      .verdict       (verdict)
   );

   // ---- output register ----
   // Loads whenever empty or being drained in the same cycle.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, verdict.size_error, 4'(verdict.class_code),
                         verdict.class_valid, slot, px[ALPHA_LANE],
                         px[2], px[1], px[0]};
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- assertions ----
   // a sprite is either classified or rejected, never both
   a_verdict_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[40] && rsp_data_ff[45]))
      else $error("class_valid and size_error both set");

   // a class code only accompanies a valid classification
   a_code_gated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[40]) |-> (rsp_data_ff[44:41] == 4'(CLS_INVISIBLE)))
      else $error("class_code set without class_valid");

   // a pixel that does not end a sprite carries no verdict
   a_mid_sprite: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tlast) |=> (rsp_data_ff[45:40] == '0))
      else $error("verdict on a non-last pixel");

endmodule : sprite_alpha_class_scan_top
`default_nettype wire

### bench/sprite_alpha_class_scan_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_alpha_class_scan_top_tb
// Self-checking bench for the sprite alpha class scanner. Pixel words go in
// on the req stream and a scoreboard with its own model of the per-sprite
// scan predicts each rsp word: pass-through bytes, effective alpha, and the
// class code or size flag on the last pixel. Directed sprites first, then
// random sprites over many channel and size settings.
// ----------------------------------------------------------------------------
module sprite_alpha_class_scan_top_tb;
   import sacs_pkg::*;

   // req word layout, lowest bits first: red, green, blue, alpha_in, sprite_slot
   typedef struct packed {
      logic [BYTE_W-1:0] slot;
      logic [BYTE_W-1:0] alpha;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] red;
   } pixel_in_type;

   // rsp word layout, lowest bits first: rgb, alpha, slot, class_valid,
   // class_code, size_error, two pad bits
   typedef struct packed {
      logic [1:0]        pad;
      logic              size_err;
      class_type         code;
      logic              cls_valid;
      logic [BYTE_W-1:0] slot;
      logic [BYTE_W-1:0] alpha;
      logic [23:0]       rgb;
   } pixel_word_type;

   typedef enum int {
      ALPHA_CLEAR, ALPHA_SOLID, ALPHA_KEYED, ALPHA_FLAT, ALPHA_SPREAD, ALPHA_NOISE
   } alpha_pattern_type;

   typedef enum int {
      RGB_FLAT, RGB_ONE_OFF, RGB_NOISE
   } rgb_pattern_type;

   localparam int RANDOM_PIXELS = 1800;
   localparam int QUIET_AFTER   = 1500;  // no idling past this many pixels
   localparam int HOLD_AT       = 600;
   localparam int LONG_HOLD     = 300;   // rsp held off this many cycles, once

   // Scan model plus store of expected rsp words.
   class sprite_scan_board;
      pixel_word_type     expected_words[$];
      logic [CHAN_W-1:0]  chan_cfg;
      logic [COUNT_W-1:0] size_cfg;
      logic [BYTE_W-1:0]  lead_byte [LANES];
      logic               lane_flat [LANES];
      logic               saw_clear, saw_solid, saw_partial, fresh_sprite;
      logic [COUNT_W-1:0] seen_pixels;
      int                 mismatches, words_checked, sprites_closed, size_rejects;
      logic [8:0]         classes_seen;

      function new();
         chan_cfg       = CHAN_RESET;
         size_cfg       = SPRITE_PIX_RESET;
         mismatches     = 0;
         words_checked  = 0;
         sprites_closed = 0;
         size_rejects   = 0;
         classes_seen   = '0;
         restart();
      endfunction

      function void restart();
         for (int c = 0; c < LANES; c++) begin
            lead_byte[c] = BYTE_MIN;
            lane_flat[c] = 1'b1;
         end
         saw_clear    = 1'b0;
         saw_solid    = 1'b0;
         saw_partial  = 1'b0;
         fresh_sprite = 1'b1;
         seen_pixels  = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_CHANNEL_COUNT: chan_cfg = val[CHAN_W-1:0];
            CSR_SPRITE_PIXELS: size_cfg = val[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function class_type grade();
         logic flat_rgb;
         flat_rgb = lane_flat[0] && lane_flat[1] && lane_flat[2];
         if (!saw_partial && !saw_solid) return CLS_INVISIBLE;
         if (!saw_partial && !saw_clear) return flat_rgb ? CLS_OPAQUE_CRGB : CLS_OPAQUE;
         if (!saw_partial) return flat_rgb ? CLS_ONEBIT_CRGB : CLS_ONEBIT;
         if (flat_rgb) return lane_flat[ALPHA_LANE] ? CLS_SEMI_CRGB_CA : CLS_SEMI_CRGB;
         return lane_flat[ALPHA_LANE] ? CLS_SEMI_CA : CLS_SEMI;
      endfunction

      function void take_pixel(pixel_in_type px, logic last);
         logic [BYTE_W-1:0] lane [LANES];
         pixel_word_type    w;
         logic              bad;
         lane[0] = px.red;
         lane[1] = px.green;
         lane[2] = px.blue;
         lane[ALPHA_LANE] = (chan_cfg == CHAN_RGB) ? BYTE_MAX : px.alpha;
         for (int c = 0; c < LANES; c++) begin
            if (fresh_sprite) lead_byte[c] = lane[c];
            else if (lead_byte[c] != lane[c]) lane_flat[c] = 1'b0;
         end
         if (lane[ALPHA_LANE] == BYTE_MIN) saw_clear = 1'b1;
         else if (lane[ALPHA_LANE] == BYTE_MAX) saw_solid = 1'b1;
         else saw_partial = 1'b1;
         fresh_sprite = 1'b0;
         if (seen_pixels < COUNT_MAX) seen_pixels++;
         w       = '0;
         w.rgb   = {lane[2], lane[1], lane[0]};
         w.alpha = lane[ALPHA_LANE];
         w.slot  = px.slot;
         w.code  = CLS_INVISIBLE;
         if (last) begin
            bad = (size_cfg == 0) || (size_cfg > DEF_MAX_PIXELS) || (seen_pixels != size_cfg);
            if (bad) begin
               w.size_err = 1'b1;
            end else begin
               w.cls_valid = 1'b1;
               w.code      = grade();
            end
            restart();
         end
         expected_words.push_back(w);
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_word(logic [47:0] raw);
         pixel_word_type got, want;
         got = pixel_word_type'(raw);
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("rsp word %h with nothing expected", raw));
            return;
         end
         want = expected_words.pop_front();
         words_checked++;
         if (got.rgb !== want.rgb)
            report_mismatch($sformatf("rgb %h, want %h", got.rgb, want.rgb));
         if (got.alpha !== want.alpha)
            report_mismatch($sformatf("alpha %h, want %h", got.alpha, want.alpha));
         if (got.slot !== want.slot)
            report_mismatch($sformatf("slot %h, want %h", got.slot, want.slot));
         if (got.cls_valid !== want.cls_valid)
            report_mismatch($sformatf("class_valid %b, want %b", got.cls_valid, want.cls_valid));
         if (got.code !== want.code)
            report_mismatch($sformatf("class_code %0d, want %0d", got.code, want.code));
         if (got.size_err !== want.size_err)
            report_mismatch($sformatf("size_error %b, want %b", got.size_err, want.size_err));
         if (want.cls_valid) classes_seen[want.code] = 1'b1;
         if (want.size_err) size_rejects++;
         if (want.cls_valid || want.size_err) sprites_closed++;
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [0:0]            csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [39:0]           req_tdata;   // red, green, blue, alpha_in, sprite_slot
   logic                  req_tlast;   // last_pixel
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [47:0]           rsp_tdata;   // rgb, alpha, slot, class_valid, class_code,
                                       // size_error, pad

   sprite_scan_board board;
   bit               idle_on;       // random gaps on both streams
   bit               hold_request;  // asks the rsp side for one long hold-off
   int               sent_pixels;

   sprite_alpha_class_scan_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic pixel_in_type pix(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [7:0] a, logic [7:0] s);
      return {s, a, b, g, r};
   endfunction

   // Offer one word; returns at the edge that took it, tvalid still high so a
   // following word goes back to back.
   task send_pixel(pixel_in_type px, logic last);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_pixel(px, last);
      sent_pixels++;
   endtask

   // Registers are only touched with the scanner empty.
   task write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      board.write_reg(idx, val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering, then wait for every expected word to come out.
   task settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task send_sprite(int len, alpha_pattern_type ap, rgb_pattern_type rp);
      pixel_in_type base, px;
      logic [7:0]   mid, flip;
      int           flip_at;
      base    = pix(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      mid     = 8'($urandom_range(1, 254));
      flip    = 8'($urandom_range(1, 255));
      flip_at = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) begin
         px = base;
         case (rp)
            RGB_NOISE: begin
               px.red   = 8'($urandom_range(0, 255));
               px.green = 8'($urandom_range(0, 255));
               px.blue  = 8'($urandom_range(0, 255));
            end
            RGB_ONE_OFF:
               // a single byte of one pixel differs from the rest
               if (i == flip_at) begin
                  case (flip_at % 3)
                     0: px.red   = px.red ^ flip;
                     1: px.green = px.green ^ flip;
                     default: px.blue = px.blue ^ flip;
                  endcase
               end
            default: ;
         endcase
         case (ap)
            ALPHA_CLEAR:  px.alpha = BYTE_MIN;
            ALPHA_SOLID:  px.alpha = BYTE_MAX;
            ALPHA_KEYED:  px.alpha = $urandom_range(0, 1) ? BYTE_MAX : BYTE_MIN;
            ALPHA_FLAT:   px.alpha = mid;
            ALPHA_SPREAD:
               case ($urandom_range(0, 2))
                  0: px.alpha = BYTE_MIN;
                  1: px.alpha = BYTE_MAX;
                  default: px.alpha = 8'($urandom_range(1, 254));
               endcase
            default:      px.alpha = 8'($urandom_range(0, 255));
         endcase
         send_pixel(px, i == len - 1);
      end
   endtask

   // rsp side: checks each taken word, then picks tready for the next cycle.
   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
         if (hold_request) begin
            // long hold-off so the output register fills and req_tready drops
            stall_left   = LONG_HOLD;
            hold_request = 1'b0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog.
   initial begin
      #(1_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [CHAN_W-1:0]  chans;
      logic [COUNT_W-1:0] size;
      int                 sprites, len;
      bit                 hold_done;
      board        = new();
      idle_on      = 1'b1;
      hold_request = 1'b0;
      hold_done    = 1'b0;
      sent_pixels  = 0;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: one-pixel sprites, byte extremes ----
      write_csr(CSR_CHANNEL_COUNT, CSR_DATA_W'(CHAN_RESET));
      write_csr(CSR_SPRITE_PIXELS, 13'd1);
      send_pixel(pix(8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1);   // invisible
      send_pixel(pix(8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 1'b1);   // opaque, flat rgb
      send_pixel(pix(8'h12, 8'h34, 8'h56, 8'h80, 8'h01), 1'b1);   // semi, flat all
      send_pixel(pix(8'h9a, 8'hbc, 8'hde, 8'hfe, 8'h80), 1'b1);
      settle();

      // ---- directed: two-pixel sprites, each of a different class ----
      write_csr(CSR_SPRITE_PIXELS, 13'd2);
      send_pixel(pix(8'h11, 8'h22, 8'h33, 8'h00, 8'h05), 1'b0);   // one-bit, flat rgb
      send_pixel(pix(8'h11, 8'h22, 8'h33, 8'hff, 8'h05), 1'b1);
      send_pixel(pix(8'h11, 8'h22, 8'h33, 8'h00, 8'h06), 1'b0);   // one-bit
      send_pixel(pix(8'h11, 8'h23, 8'h33, 8'hff, 8'h06), 1'b1);
      send_pixel(pix(8'h40, 8'h50, 8'h60, 8'hff, 8'h07), 1'b0);   // opaque
      send_pixel(pix(8'h40, 8'h50, 8'h61, 8'hff, 8'h07), 1'b1);
      send_pixel(pix(8'h40, 8'h50, 8'h60, 8'h00, 8'h08), 1'b0);   // invisible, rgb varies
      send_pixel(pix(8'h41, 8'h50, 8'h60, 8'h00, 8'h08), 1'b1);
      send_pixel(pix(8'h77, 8'h77, 8'h77, 8'h80, 8'h09), 1'b0);   // semi, flat rgb
      send_pixel(pix(8'h77, 8'h77, 8'h77, 8'h81, 8'h09), 1'b1);
      send_pixel(pix(8'h01, 8'h02, 8'h03, 8'h80, 8'h0a), 1'b0);   // semi, flat alpha
      send_pixel(pix(8'h04, 8'h02, 8'h03, 8'h80, 8'h0a), 1'b1);
      send_pixel(pix(8'h01, 8'h02, 8'h03, 8'h80, 8'h0b), 1'b0);   // semi
      send_pixel(pix(8'h01, 8'hf2, 8'h03, 8'hc8, 8'h0b), 1'b1);
      // size mismatch: short and long sprite
      send_pixel(pix(8'haa, 8'h55, 8'haa, 8'hff, 8'h0c), 1'b1);
      send_pixel(pix(8'haa, 8'h55, 8'haa, 8'hff, 8'h0d), 1'b0);
      send_pixel(pix(8'haa, 8'h55, 8'haa, 8'hff, 8'h0d), 1'b0);
      send_pixel(pix(8'haa, 8'h55, 8'haa, 8'hff, 8'h0d), 1'b1);
      settle();

      // ---- directed: RGB mode ignores alpha_in ----
      write_csr(CSR_CHANNEL_COUNT, CSR_DATA_W'(CHAN_RGB));
      send_pixel(pix(8'h10, 8'h20, 8'h30, 8'h00, 8'hfe), 1'b0);   // opaque, flat rgb
      send_pixel(pix(8'h10, 8'h20, 8'h30, 8'h4d, 8'hfe), 1'b1);
      send_pixel(pix(8'h10, 8'h20, 8'h30, 8'h00, 8'hfd), 1'b0);   // opaque
      send_pixel(pix(8'h10, 8'h20, 8'h31, 8'h80, 8'hfd), 1'b1);
      settle();

      // ---- random sprites over many register settings ----
      while (sent_pixels < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0, 1, 2: chans = CHAN_RGB;
            3:       chans = 3'd0;
            4:       chans = 3'd7;
            5:       chans = CHAN_W'($urandom_range(0, 7));
            default: chans = CHAN_RESET;
         endcase
         case ($urandom_range(0, 19))
            0:       size = 13'd0;        // out of range, always rejected
            1:       size = 13'd4097;     // above the maximum
            2:       size = 13'd8191;
            3:       size = SPRITE_PIX_RESET;
            default: size = COUNT_W'($urandom_range(1, 12));
         endcase
         write_csr(CSR_CHANNEL_COUNT, CSR_DATA_W'(chans));
         write_csr(CSR_SPRITE_PIXELS, size);
         // the hold-off starts ahead of a whole group, so words keep coming
         if (!hold_done && sent_pixels >= HOLD_AT) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         sprites = $urandom_range(3, 10);
         for (int k = 0; k < sprites; k++) begin
            idle_on = (sent_pixels < QUIET_AFTER);
            if (size == 0 || size > DEF_MAX_PIXELS) begin
               len = $urandom_range(1, 8);
            end else if ($urandom_range(0, 9) < 8) begin
               len = int'(size);
            end else begin
               case ($urandom_range(0, 2))
                  0:       len = (size > 1) ? int'(size) - 1 : 2;
                  1:       len = int'(size) + 1;
                  default: len = $urandom_range(1, 16);
               endcase
            end
            send_sprite(len, alpha_pattern_type'($urandom_range(0, 5)),
                        rgb_pattern_type'($urandom_range(0, 2)));
         end
         settle();
      end
      repeat (4) @(posedge clock);

      $display("Run covered %0d pixel words, %0d sprites closed, %0d rejected on size.",
               board.words_checked, board.sprites_closed, board.size_rejects);
      $display("Class codes graded (class 8 leftmost): %b", board.classes_seen);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
